### hdl/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg
// Shared types and constants for the session history ring: command codes,
// field widths, the stored entry layout, controller states and the command
// bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package shr_pkg;

    localparam int OPCODE_W = 4;
    localparam int URL_W    = 32;
    localparam int DOC_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int DELTA_W  = 16;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;
    localparam int GEN_W    = 64;
    localparam int CFG_W    = 9;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 9'd200;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_DOC      = 4'd0,
        OP_PUSH_STATE    = 4'd1,
        OP_REPLACE_STATE = 4'd2,
        OP_SET_TITLE     = 4'd3,
        OP_SET_SCROLL    = 4'd4,
        OP_SET_URL       = 4'd5,
        OP_GO            = 4'd6,
        OP_CURRENT       = 4'd7,
        OP_CLEAR         = 4'd8
    } shr_op_t;

    typedef struct packed {
        logic [URL_W-1:0]    url;
        logic [DOC_W-1:0]    document;
        logic [HANDLE_W-1:0] state;
        logic [HANDLE_W-1:0] title;
        logic [HANDLE_W-1:0] scroll;
    } shr_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_FETCH,
        ST_RESPOND
    } shr_state_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic apply;
        logic load_out;
    } shr_ctl_t;

endpackage

`default_nettype wire

### hdl/shr_cmd_if.sv
// ----------------------------------------------------------------------------
// shr_cmd_if
// Command channel of the session history ring: valid, ready and the
// operands of one history command.
// ----------------------------------------------------------------------------
`default_nettype none

interface shr_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [shr_pkg::OPCODE_W-1:0]        opcode;
    logic [shr_pkg::URL_W-1:0]           url_handle;
    logic [shr_pkg::DOC_W-1:0]           document_id;
    logic [shr_pkg::HANDLE_W-1:0]        state_handle;
    logic [shr_pkg::HANDLE_W-1:0]        title_handle;
    logic [shr_pkg::HANDLE_W-1:0]        scroll_bits;
    logic signed [shr_pkg::DELTA_W-1:0]  step_delta;

    modport source (
        output valid, opcode, url_handle, document_id, state_handle,
               title_handle, scroll_bits, step_delta,
        input  ready
    );

    modport sink (
        input  valid, opcode, url_handle, document_id, state_handle,
               title_handle, scroll_bits, step_delta,
        output ready
    );
endinterface

`default_nettype wire

### hdl/shr_rsp_if.sv
// ----------------------------------------------------------------------------
// shr_rsp_if
// Result channel of the session history ring: valid, ready and the current
// entry with cursor, count and change counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface shr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [shr_pkg::URL_W-1:0]     entry_url;
    logic [shr_pkg::DOC_W-1:0]     entry_document;
    logic [shr_pkg::HANDLE_W-1:0]  entry_state;
    logic [shr_pkg::HANDLE_W-1:0]  entry_title;
    logic [shr_pkg::HANDLE_W-1:0]  entry_scroll;
    logic [shr_pkg::POS_W-1:0]     position;
    logic [shr_pkg::COUNT_W-1:0]   entry_count;
    logic [shr_pkg::GEN_W-1:0]     change_count;

    modport source (
        output valid, ok, entry_url, entry_document, entry_state, entry_title,
               entry_scroll, position, entry_count, change_count,
        input  ready
    );

    modport sink (
        input  valid, ok, entry_url, entry_document, entry_state, entry_title,
               entry_scroll, position, entry_count, change_count,
        output ready
    );
endinterface

`default_nettype wire

### hdl/shr_ctrl.sv
// ----------------------------------------------------------------------------
// shr_ctrl
// Controller of the session history ring. Sequences each command through
// capture and entry read, apply with write-back, re-read of the entry under
// the cursor, and loading of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output shr_pkg::shr_ctl_t     ctl
);
    import shr_pkg::*;

    shr_state_t state_reg;
    shr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctl.capture  = 1'b0;
        ctl.rd_en    = 1'b0;
        ctl.apply    = 1'b0;
        ctl.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
                ctl.rd_en   = in_valid;
            end
            ST_APPLY:
            begin
                ctl.apply = 1'b1;
            end
            ST_FETCH:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_RESPOND:
            begin
                ctl.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### hdl/shr_datapath.sv
// ----------------------------------------------------------------------------
// shr_datapath
// Datapath of the session history ring: entry memory, ring pointers, cursor,
// entry count, change counter, the limit register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module shr_datapath #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire shr_pkg::shr_ctl_t                 ctl,
    input  wire logic                              cfg_wr_en,
    input  wire logic [shr_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic [shr_pkg::OPCODE_W-1:0]      in_opcode,
    input  wire logic [shr_pkg::URL_W-1:0]         in_url,
    input  wire logic [shr_pkg::DOC_W-1:0]         in_document,
    input  wire logic [shr_pkg::HANDLE_W-1:0]      in_state,
    input  wire logic [shr_pkg::HANDLE_W-1:0]      in_title,
    input  wire logic [shr_pkg::HANDLE_W-1:0]      in_scroll,
    input  wire logic signed [shr_pkg::DELTA_W-1:0] in_delta,
    output logic                                   out_ok,
    output logic [shr_pkg::URL_W-1:0]              out_url,
    output logic [shr_pkg::DOC_W-1:0]              out_document,
    output logic [shr_pkg::HANDLE_W-1:0]           out_state,
    output logic [shr_pkg::HANDLE_W-1:0]           out_title,
    output logic [shr_pkg::HANDLE_W-1:0]           out_scroll,
    output logic [shr_pkg::POS_W-1:0]              out_position,
    output logic [shr_pkg::COUNT_W-1:0]            out_count,
    output logic [shr_pkg::GEN_W-1:0]              out_change
);
    import shr_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TGT_W = ((CNT_W > DELTA_W) ? CNT_W : DELTA_W) + 2;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(pos);
        if (sum >= SUM_W'(RING_DEPTH))
        begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    shr_entry_t mem [RING_DEPTH];

    logic [PTR_W-1:0]         cursor_reg;
    logic [PTR_W-1:0]         cursor_next;
    logic [CNT_W-1:0]         held_reg;
    logic [CNT_W-1:0]         held_next;
    logic [PTR_W-1:0]         oldest_reg;
    logic [PTR_W-1:0]         oldest_next;
    logic [GEN_W-1:0]         gen_reg;
    logic [GEN_W-1:0]         gen_next;
    logic [CFG_W-1:0]         max_entries_reg;
    logic                     ok_reg;
    logic                     ok_next;

    logic [OPCODE_W-1:0]      op_reg;
    logic [URL_W-1:0]         url_reg;
    logic [DOC_W-1:0]         doc_reg;
    logic [HANDLE_W-1:0]      state_reg;
    logic [HANDLE_W-1:0]      title_reg;
    logic [HANDLE_W-1:0]      scroll_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    shr_entry_t               rd_data_reg;

    logic [PTR_W-1:0]         slot_cur;
    logic                     have;
    logic [CNT_W-1:0]         limit;
    logic [CNT_W-1:0]         keep;
    logic [CNT_W-1:0]         new_held;
    logic signed [TGT_W-1:0]  target;
    logic signed [TGT_W-1:0]  held_wide;
    logic                     push_en;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    shr_entry_t               wr_data;

    assign slot_cur  = slot_of(oldest_reg, CNT_W'(cursor_reg));
    assign have      = held_reg != '0;
    assign keep      = have ? (CNT_W'(cursor_reg) + CNT_W'(1)) : '0;
    assign target    = $signed({{(TGT_W - PTR_W){1'b0}}, cursor_reg}) + TGT_W'(delta_reg);
    assign held_wide = $signed({{(TGT_W - CNT_W){1'b0}}, held_reg});

    always_comb
    begin
        if (max_entries_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(max_entries_reg) > 32'(RING_DEPTH))
        begin
            limit = CNT_W'(RING_DEPTH);
        end
        else
        begin
            limit = CNT_W'(max_entries_reg);
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        held_next   = held_reg;
        oldest_next = oldest_reg;
        gen_next    = gen_reg;
        ok_next     = ok_reg;
        new_held    = keep + CNT_W'(1);
        push_en     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = slot_cur;
        wr_data     = rd_data_reg;
        if (ctl.apply)
        begin
            ok_next = 1'b0;
            case (op_reg)
                OP_PUSH_DOC:
                begin
                    push_en = 1'b1;
                    wr_data = '{url: url_reg, document: doc_reg, state: '0,
                                title: '0, scroll: '0};
                end
                OP_PUSH_STATE:
                begin
                    push_en = have;
                    wr_data = '{url: url_reg, document: rd_data_reg.document,
                                state: state_reg, title: '0, scroll: '0};
                end
                OP_REPLACE_STATE:
                begin
                    wr_en         = have;
                    wr_data.url   = url_reg;
                    wr_data.state = state_reg;
                    ok_next       = have;
                    if (have)
                    begin
                        gen_next = gen_reg + GEN_W'(1);
                    end
                end
                OP_SET_TITLE:
                begin
                    wr_en         = have;
                    wr_data.title = title_reg;
                    ok_next       = have;
                end
                OP_SET_SCROLL:
                begin
                    wr_en          = have;
                    wr_data.scroll = scroll_reg;
                    ok_next        = have;
                end
                OP_SET_URL:
                begin
                    wr_en       = have;
                    wr_data.url = url_reg;
                    ok_next     = have;
                end
                OP_GO:
                begin
                    if (have && delta_reg != '0 && !target[TGT_W-1] && target < held_wide)
                    begin
                        cursor_next = target[PTR_W-1:0];
                        gen_next    = gen_reg + GEN_W'(1);
                        ok_next     = 1'b1;
                    end
                end
                OP_CURRENT:
                begin
                    ok_next = have;
                end
                OP_CLEAR:
                begin
                    held_next   = '0;
                    cursor_next = '0;
                    oldest_next = '0;
                    gen_next    = gen_reg + GEN_W'(1);
                    ok_next     = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
            if (push_en)
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(oldest_reg, keep);
                ok_next = 1'b1;
                if (keep >= limit)
                begin
                    new_held    = keep;
                    oldest_next = (oldest_reg == PTR_W'(RING_DEPTH - 1)) ?
                                  '0 : oldest_reg + PTR_W'(1);
                end
                held_next   = new_held;
                cursor_next = PTR_W'(new_held - CNT_W'(1));
                gen_next    = gen_reg + GEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg      <= '0;
            held_reg        <= '0;
            oldest_reg      <= '0;
            gen_reg         <= '0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            cursor_reg <= cursor_next;
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
            gen_reg    <= gen_next;
            if (cfg_wr_en)
            begin
                max_entries_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (ctl.capture)
        begin
            op_reg     <= in_opcode;
            url_reg    <= in_url;
            doc_reg    <= in_document;
            state_reg  <= in_state;
            title_reg  <= in_title;
            scroll_reg <= in_scroll;
            delta_reg  <= in_delta;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[slot_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_ok       <= ok_reg;
            out_position <= POS_W'(cursor_reg);
            out_count    <= COUNT_W'(held_reg);
            out_change   <= gen_reg;
            if (have)
            begin
                out_url      <= rd_data_reg.url;
                out_document <= rd_data_reg.document;
                out_state    <= rd_data_reg.state;
                out_title    <= rd_data_reg.title;
                out_scroll   <= rd_data_reg.scroll;
            end
            else
            begin
                out_url      <= '0;
                out_document <= '0;
                out_state    <= '0;
                out_title    <= '0;
                out_scroll   <= '0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/session_history_ring.sv
// ----------------------------------------------------------------------------
// session_history_ring
// From its acceptance to its result in the output register, a command
// runs in order: the entry under the cursor is read as it is taken, it is
// applied and, if it changes an entry, written back in the next cycle, the
// entry under the new cursor is read again, and the result is loaded once
// the output register is empty or being taken. The controller is ready
// again in the cycle after the result is loaded, so a new command is taken
// only after the last result is loaded, even while that result waits to be
// taken; a result not taken holds the next one back in the respond state.
// Entries need no clearing after reset, so commands are accepted once reset
// ends. The limit register is to be written through cfg_wr_en and
// cfg_wr_data only while no command is in flight, which is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module session_history_ring #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [shr_pkg::CFG_W-1:0]  cfg_wr_data,
    shr_cmd_if.sink                         cmd,
    shr_rsp_if.source                       rsp
);
    import shr_pkg::*;

    shr_ctl_t ctl;

    shr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    shr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_opcode    (cmd.opcode),
        .in_url       (cmd.url_handle),
        .in_document  (cmd.document_id),
        .in_state     (cmd.state_handle),
        .in_title     (cmd.title_handle),
        .in_scroll    (cmd.scroll_bits),
        .in_delta     (cmd.step_delta),
        .out_ok       (rsp.ok),
        .out_url      (rsp.entry_url),
        .out_document (rsp.entry_document),
        .out_state    (rsp.entry_state),
        .out_title    (rsp.entry_title),
        .out_scroll   (rsp.entry_scroll),
        .out_position (rsp.position),
        .out_count    (rsp.entry_count),
        .out_change   (rsp.change_count)
    );

`ifndef NO_ASSERTIONS
    // A command in flight blocks the next one: ready is low in the cycle after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while a transaction was in flight");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_out && rsp.valid) |-> rsp.ready)
        else $error("result register overwritten before transaction completed");

    // An empty list always reports a cursor of zero and a blank entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.entry_count == '0) |->
            (rsp.position == '0 && rsp.entry_url == '0 && rsp.entry_document == '0))
        else $error("empty history reported a nonzero cursor or entry");
`endif

endmodule

`default_nettype wire
